/* rtl/core/crc32cmb_pkg.sv */
// package for the crc32 combine block: widths, polynomial and operator table
// no dependencies; used by every module in rtl/core
package crc32cmb_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int CRC_W       = 32;
	localparam int IDX_W       = (LENGTH_BITS > 1) ? $clog2(LENGTH_BITS) : 1;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

	// column i of a gf2 operator is the image of bit i
	typedef logic [CRC_W-1:0][CRC_W-1:0]       mat_t;
	typedef logic [LENGTH_BITS-1:0][CRC_W-1:0][CRC_W-1:0] op_table_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	function automatic logic [CRC_W-1:0] gf2_apply(input mat_t op, input logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (v[i]) begin
				acc = acc ^ op[i];
			end
		end
		return acc;
	endfunction

	function automatic mat_t gf2_square(input mat_t op);
		mat_t sq;
		for (int i = 0; i < CRC_W; i++) begin
			sq[i] = gf2_apply(op, op[i]);
		end
		return sq;
	endfunction

	// operator k appends 2^k zero bytes; evaluated at elaboration only
	function automatic op_table_t build_ops();
		mat_t      op;
		op_table_t t;
		op[0] = CRC_POLY;
		for (int i = 1; i < CRC_W; i++) begin
			op[i] = CRC_W'(1) << (i - 1);
		end
		op = gf2_square(op);
		op = gf2_square(op);
		op = gf2_square(op);
		for (int k = 0; k < LENGTH_BITS; k++) begin
			t[k] = op;
			op   = gf2_square(op);
		end
		return t;
	endfunction

	localparam op_table_t OP_TABLE = build_ops();

endpackage

/* rtl/core/crc32cmb_gf2_apply.sv */
// shared gf2 matrix-vector unit: and-xor of 32 operator columns
// depends on crc32cmb_pkg
module crc32cmb_gf2_apply (
	input  crc32cmb_pkg::mat_t              op,
	input  logic [crc32cmb_pkg::CRC_W-1:0]  vec_in,
	output logic [crc32cmb_pkg::CRC_W-1:0]  vec_out
);
	import crc32cmb_pkg::*;

	always_comb begin
		vec_out = '0;
		for (int i = 0; i < CRC_W; i++) begin
			vec_out = vec_out ^ (op[i] & {CRC_W{vec_in[i]}});
		end
	end

endmodule

/* rtl/core/crc32_combine_top.sv */
// crc32 combine top level: sequencer over one gf2 apply unit and operator rom
// depends on crc32cmb_pkg and crc32cmb_gf2_apply
// one length bit per cycle, LENGTH_BITS steps on the single shared gf2 unit, except that the last
// step waits while a stalled result still occupies the output register
// no new transfer is taken until the block is back in idle after the last step
// the next input is taken while a finished result waits in the output register
// reset: arst_n async active low clears the sequencer and output valid; no memory to clear
module crc32_combine_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [crc32cmb_pkg::CRC_W-1:0]        first_crc,
	input  logic [crc32cmb_pkg::CRC_W-1:0]        second_crc,
	input  logic [crc32cmb_pkg::LENGTH_BITS-1:0]  second_length,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [crc32cmb_pkg::CRC_W-1:0]        combined_crc
);
	import crc32cmb_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LENGTH_BITS - 1);

	state_t                 state_q;
	logic [IDX_W-1:0]       cnt_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [CRC_W-1:0]       crc_q;
	logic [CRC_W-1:0]       crc2_q;
	logic                   out_valid_q;
	logic [CRC_W-1:0]       out_crc_q;

	logic [CRC_W-1:0]       applied;
	logic [CRC_W-1:0]       next_crc;
	logic                   in_xfer;
	logic                   slot_free;
	logic                   last_step;

	// operator for the current length bit comes straight from the constant rom
	crc32cmb_gf2_apply u_apply (
		.op      (OP_TABLE[cnt_q]),
		.vec_in  (crc_q),
		.vec_out (applied)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	// output slot can take a result if empty or being drained this cycle
	assign slot_free = !out_valid_q || !out_stall;
	assign last_step = (state_q == ST_RUN) && (cnt_q == LAST_IDX) && slot_free;
	assign next_crc  = len_q[0] ? applied : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a drained result clears valid unless a new one lands this cycle
			if (out_valid_q && !out_stall && !last_step) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (cnt_q != LAST_IDX) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (slot_free) begin
						// final length bit: result lands in the output register
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			crc_q  <= first_crc;
			len_q  <= second_length;
			// zero length passes the first crc through unchanged
			crc2_q <= (second_length == '0) ? '0 : second_crc;
		end else if ((state_q == ST_RUN) && (cnt_q != LAST_IDX)) begin
			crc_q <= next_crc;
			len_q <= len_q >> 1;
		end
		if (last_step) begin
			out_crc_q <= next_crc ^ crc2_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign combined_crc = out_crc_q;

endmodule

/* rtl/core/crc32cmb_checker.sv */
// port-level checker for crc32_combine_top, attached by bind
// depends on crc32cmb_pkg
module crc32cmb_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [crc32cmb_pkg::CRC_W-1:0]        first_crc,
	input  logic [crc32cmb_pkg::CRC_W-1:0]        second_crc,
	input  logic [crc32cmb_pkg::LENGTH_BITS-1:0]  second_length,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic [crc32cmb_pkg::CRC_W-1:0]        combined_crc
);
	import crc32cmb_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(combined_crc))
		else $error("stalled result changed");

	// an accepted transfer makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("not busy after input transfer");

	// a new result only appears after a busy cycle
	a_rose_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	// finishing always loads the output register
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("finished without result");

endmodule

bind crc32_combine_top crc32cmb_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.first_crc     (first_crc),
	.second_crc    (second_crc),
	.second_length (second_length),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.combined_crc  (combined_crc)
);

/* bench/crc_join_sb_pkg.sv */
// result store for the crc32 combine bench: predicts combined_crc per input transfer
// depends on crc32cmb_pkg for the crc and length widths
package crc_join_sb_pkg;

	localparam int CW = crc32cmb_pkg::CRC_W;
	localparam int LW = crc32cmb_pkg::LENGTH_BITS;
	localparam logic [CW-1:0] REFLECTED_POLY = 32'hEDB88320;

	typedef enum {MATCH_OK, MATCH_WRONG, MATCH_UNEXPECTED} match_t;

	// column i holds where state bit i lands after the zero run
	typedef logic [CW-1:0][CW-1:0] zero_run_t;

	class crc_join_board;
		zero_run_t        byte_pow_ops [LW];
		logic [CW-1:0]    pending_crcs [$];

		function new();
			zero_run_t   one_byte;
			logic [CW-1:0] c;
			// derive the one-byte operator by clocking 8 zero bits into each unit state
			for (int i = 0; i < CW; i++) begin
				c = CW'(1) << i;
				for (int b = 0; b < 8; b++) begin
					c = c[0] ? ((c >> 1) ^ REFLECTED_POLY) : (c >> 1);
				end
				one_byte[i] = c;
			end
			byte_pow_ops[0] = one_byte;
			for (int k = 1; k < LW; k++) begin
				for (int i = 0; i < CW; i++) begin
					byte_pow_ops[k][i] = shift_zeros(byte_pow_ops[k-1], byte_pow_ops[k-1][i]);
				end
			end
		endfunction

		function logic [CW-1:0] shift_zeros(input zero_run_t op, input logic [CW-1:0] v);
			logic [CW-1:0] acc;
			acc = '0;
			for (int i = 0; i < CW; i++) begin
				if (v[i]) begin
					acc ^= op[i];
				end
			end
			return acc;
		endfunction

		function logic [CW-1:0] joined_crc(input logic [CW-1:0] head, input logic [CW-1:0] tail,
				input logic [LW-1:0] tail_len);
			logic [CW-1:0] c;
			c = head;
			if (tail_len == '0) begin
				return head;
			end
			for (int k = 0; k < LW; k++) begin
				if (tail_len[k]) begin
					c = shift_zeros(byte_pow_ops[k], c);
				end
			end
			return c ^ tail;
		endfunction

		function void note_transfer(input logic [CW-1:0] head, input logic [CW-1:0] tail,
				input logic [LW-1:0] tail_len);
			pending_crcs.push_back(joined_crc(head, tail, tail_len));
		endfunction

		function match_t check_result(input logic [CW-1:0] got, output logic [CW-1:0] want);
			want = '0;
			if (pending_crcs.size() == 0) begin
				return MATCH_UNEXPECTED;
			end
			want = pending_crcs.pop_front();
			return (got === want) ? MATCH_OK : MATCH_WRONG;
		endfunction

		function int waiting();
			return pending_crcs.size();
		endfunction
	endclass

endpackage

/* bench/tb.sv */
// bench top for crc32_combine_top: directed and random transfers with bursty input and stalls
// depends on crc32cmb_pkg, crc_join_sb_pkg and the rtl under rtl/core
module tb;
	import crc_join_sb_pkg::*;

	localparam int CW          = crc32cmb_pkg::CRC_W;
	localparam int LW          = crc32cmb_pkg::LENGTH_BITS;
	localparam int RANDOM_ITEMS = 1500;
	// overall budget for the watchdog below
	localparam int CYCLE_LIMIT = 900_000;
	localparam int TAIL_CYCLES = 2 * LW + 16;

	typedef enum {RX_FREE, RX_CHOPPY, RX_HELD} rx_phase_t;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	logic [CW-1:0]  first_crc;
	logic [CW-1:0]  second_crc;
	logic [LW-1:0]  second_length;
	logic           out_valid;
	logic           out_stall;
	logic [CW-1:0]  combined_crc;

	crc_join_board  board;
	int             fail_count = 0;

	crc32_combine_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.first_crc     (first_crc),
		.second_crc    (second_crc),
		.second_length (second_length),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.combined_crc  (combined_crc)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// one line per mismatch, counted for the final verdict
	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		fail_count++;
	endtask

	// present one item and hold it until the transfer happens; called right after a rising edge
	// all reads below see pre-edge values since the dut updates in the nba region
	task automatic push_item(input logic [CW-1:0] head, input logic [CW-1:0] tail,
			input logic [LW-1:0] tail_len);
		in_valid      <= 1'b1;
		first_crc     <= head;
		second_crc    <= tail;
		second_length <= tail_len;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		board.note_transfer(head, tail, tail_len);
	endtask

	// drop valid for a while; payload gets junk so only valid qualifies it
	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			in_valid      <= 1'b0;
			first_crc     <= $urandom;
			second_crc    <= $urandom;
			second_length <= LW'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	// hold off input until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (board.waiting() != 0);
	endtask

	// length mix: short runs and full-width random values, some zero and single set bits
	function automatic logic [LW-1:0] pick_length();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			return '0;
		end else if (pick <= 4) begin
			return LW'($urandom_range(1, 300));
		end else if (pick == 5) begin
			return LW'(1) << $urandom_range(0, LW - 1);
		end
		return LW'($urandom);
	endfunction

	function automatic logic [CW-1:0] pick_crc();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return '1;
		end
		return CW'($urandom);
	endfunction

	// result side: check each transfer out, then choose the next stall value
	// stall runs in phases: free flow, random chatter, or held high for a stretch
	initial begin : result_side
		rx_phase_t     phase;
		int            phase_left;
		logic [CW-1:0] want;
		phase      = RX_FREE;
		phase_left = 0;
		out_stall  <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				case (board.check_result(combined_crc, want))
					MATCH_WRONG: report_mismatch($sformatf("combined_crc %08h, expected %08h",
						combined_crc, want));
					MATCH_UNEXPECTED: report_mismatch($sformatf("combined_crc %08h with none pending",
						combined_crc));
					default: ;
				endcase
			end
			if (phase_left == 0) begin
				phase      = rx_phase_t'($urandom_range(0, 2));
				phase_left = $urandom_range(1, 48);
			end
			phase_left--;
			case (phase)
				RX_FREE:   out_stall <= 1'b0;
				RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
				default:   out_stall <= 1'b1;
			endcase
		end
	end

	// hard stop in case the dut hangs
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, board.waiting());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : input_side
		int burst;
		int sent;
		board = new();
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		first_crc     <= '0;
		second_crc    <= '0;
		second_length <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length passes first_crc through and ignores second_crc
		push_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		push_item(32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000);
		// single byte tails, including the crcs of "a" and "b"
		push_item(32'hE8B7_BE43, 32'h71BE_EB6D, 32'h0000_0001);
		push_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
		push_item(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
		push_item(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		push_item(32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
		// short lengths exercising the low operators
		push_item(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0002);
		push_item(32'h0000_0001, 32'h8000_0000, 32'h0000_0003);
		push_item(32'hCAFE_F00D, 32'h0BAD_BEEF, 32'h0000_0100);
		push_item(32'hDEAD_BEEF, 32'h1357_9BDF, 32'h0000_00FF);
		// full-width and alternating length patterns
		push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		push_item(32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h8000_0000);
		push_item(32'h3C3C_3C3C, 32'hC3C3_C3C3, 32'h7FFF_FFFF);
		push_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		push_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		push_item(32'h0123_4567, 32'h89AB_CDEF, 32'h0001_0000);

		// sender waits for the pipeline to empty before going random
		drain_results();

		// random part: bursts of back-to-back transfers, most of them followed by a random gap
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				push_item(pick_crc(), pick_crc(), pick_length());
				sent++;
			end
			if (sent == RANDOM_ITEMS / 2) begin
				drain_results();
			end else if ($urandom_range(0, 3) != 0) begin
				idle_sender($urandom_range(1, 40));
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.waiting() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", board.waiting()));
		end
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
